>>> rtl/obb_pkg.sv
// ----------------------------------------------------------------------------
// obb_pkg: shared constants and helpers for the 2D box overlap test
// Widths of the input fields, the Q14 unit value and the shared types.
// ----------------------------------------------------------------------------
package obb_pkg;

    localparam int ANGLE_BITS = 12;
    localparam int COORD_BITS = 20;
    localparam int SIZE_BITS  = 16;
    localparam int Q14_ONE    = 16384;

    // Input item width: 4 coordinates, 4 sizes, 2 angles, padded to bytes
    localparam int IN_BITS    = 4*COORD_BITS + 4*SIZE_BITS + 2*ANGLE_BITS;
    localparam int IN_BYTES_W = ((IN_BITS + 7) / 8) * 8;

    typedef logic signed [COORD_BITS:0] t_diff;   // centre difference
    typedef logic signed [15:0]         t_q14;    // signed Q14 sine/cosine

endpackage

>>> rtl/obb_overlap_test_2d.sv
// ----------------------------------------------------------------------------
// obb_overlap_test_2d: separating axis overlap test for two rotated boxes
// Reports overlap = 1 when none of the four box axes separates the boxes.
// ----------------------------------------------------------------------------
// Channel | Dir | Handshake           | Payload
// s_axis  | in  | s_axis_tvalid/ready | tdata: both boxes, see port comment
// m_axis  | out | m_axis_tvalid/ready | tdata: overlap in bit 0
//
// One item per cycle while the output does not stall; each item passes the sine,
// axis product and sum stages of the pipeline on its way to the output register.
// Reset (synchronous, active low) clears every stage's valid bit.
// A stall at the output holds all stages at once; s_axis_tready follows
// m_axis_tready or an empty output register, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module obb_overlap_test_2d
    import obb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata, low bit up: left_center_x[20] left_center_y[20] left_width[16]
    // left_height[16] left_angle[12] right_center_x[20] right_center_y[20]
    // right_width[16] right_height[16] right_angle[12], zero pad to 168
    input  logic [IN_BYTES_W-1:0] s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata, low bit up: overlap[1], zero pad to 8
    output logic [7:0]            m_axis_tdata
);

    localparam int NST = 8;

    // Whole pipeline advances together when the output can move on
    logic w_adv;
    logic [NST-1:0] r_vld;

    assign w_adv         = !r_vld[NST-1] || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign m_axis_tvalid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NST-2:0], s_axis_tvalid};
        end
    end

    // ---- field unpacking ----
    localparam int P_LX = 0;
    localparam int P_LY = P_LX + COORD_BITS;
    localparam int P_LW = P_LY + COORD_BITS;
    localparam int P_LH = P_LW + SIZE_BITS;
    localparam int P_LA = P_LH + SIZE_BITS;
    localparam int P_RX = P_LA + ANGLE_BITS;
    localparam int P_RY = P_RX + COORD_BITS;
    localparam int P_RW = P_RY + COORD_BITS;
    localparam int P_RH = P_RW + SIZE_BITS;
    localparam int P_RA = P_RH + SIZE_BITS;

    logic signed [COORD_BITS-1:0] w_lx, w_ly, w_rx, w_ry;
    logic [ANGLE_BITS-1:0]        w_la, w_ra;
    assign w_lx = s_axis_tdata[P_LX +: COORD_BITS];
    assign w_ly = s_axis_tdata[P_LY +: COORD_BITS];
    assign w_la = s_axis_tdata[P_LA +: ANGLE_BITS];
    assign w_rx = s_axis_tdata[P_RX +: COORD_BITS];
    assign w_ry = s_axis_tdata[P_RY +: COORD_BITS];
    assign w_ra = s_axis_tdata[P_RA +: ANGLE_BITS];

    // Sine lanes: 0 = sin left, 1 = cos left, 2 = sin right, 3 = cos right
    // ---- stage 1: phase, quadrant fold, centre difference ----
    logic [14:0]    r1_x  [4];
    logic [3:0]     r1_neg;
    t_diff          r1_dx, r1_dy;
    logic [4*SIZE_BITS-1:0] r1_sz;
    logic [15:0]    w_ph  [4];
    logic [15:0]    w_pl, w_pr;

    assign w_pl = 16'(w_la) << (16 - ANGLE_BITS);
    assign w_pr = 16'(w_ra) << (16 - ANGLE_BITS);
    assign w_ph[0] = w_pl;
    assign w_ph[1] = w_pl + 16'h4000;
    assign w_ph[2] = w_pr;
    assign w_ph[3] = w_pr + 16'h4000;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 4; i++) begin
                r1_x[i]   <= w_ph[i][14] ? 15'(Q14_ONE) - {1'b0, w_ph[i][13:0]}
                                         : {1'b0, w_ph[i][13:0]};
                r1_neg[i] <= w_ph[i][15];
            end
            r1_dx <= t_diff'(w_lx) - t_diff'(w_rx);
            r1_dy <= t_diff'(w_ly) - t_diff'(w_ry);
            // sizes in lane order: left height, left width, right height, right width
            r1_sz <= {s_axis_tdata[P_RW +: SIZE_BITS], s_axis_tdata[P_RH +: SIZE_BITS],
                      s_axis_tdata[P_LW +: SIZE_BITS], s_axis_tdata[P_LH +: SIZE_BITS]};
        end
    end

    // ---- stage 2: x2 = x*x >> 14 ----
    logic [14:0] r2_x [4];
    logic [14:0] r2_x2 [4];
    logic [3:0]  r2_neg;
    t_diff       r2_dx, r2_dy;
    logic [4*SIZE_BITS-1:0] r2_sz;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 4; i++) begin
                r2_x[i]  <= r1_x[i];
                r2_x2[i] <= 15'((30'(r1_x[i]) * 30'(r1_x[i])) >> 14);
            end
            r2_neg <= r1_neg; r2_dx <= r1_dx; r2_dy <= r1_dy; r2_sz <= r1_sz;
        end
    end

    // ---- stage 3: t = 10512 - (x2*1160 >> 14) ----
    logic [14:0] r3_x [4], r3_x2 [4], r3_t [4];
    logic [3:0]  r3_neg;
    t_diff       r3_dx, r3_dy;
    logic [4*SIZE_BITS-1:0] r3_sz;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 4; i++) begin
                r3_x[i]  <= r2_x[i];
                r3_x2[i] <= r2_x2[i];
                r3_t[i]  <= 15'd10512 - 15'((26'(r2_x2[i]) * 26'd1160) >> 14);
            end
            r3_neg <= r2_neg; r3_dx <= r2_dx; r3_dy <= r2_dy; r3_sz <= r2_sz;
        end
    end

    // ---- stage 4: u = 25736 - (x2*t >> 14) ----
    logic [14:0] r4_x [4];
    logic [14:0] r4_u [4];
    logic [3:0]  r4_neg;
    t_diff       r4_dx, r4_dy;
    logic [4*SIZE_BITS-1:0] r4_sz;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 4; i++) begin
                r4_x[i] <= r3_x[i];
                r4_u[i] <= 15'd25736 - 15'((30'(r3_x2[i]) * 30'(r3_t[i])) >> 14);
            end
            r4_neg <= r3_neg; r4_dx <= r3_dx; r4_dy <= r3_dy; r4_sz <= r3_sz;
        end
    end

    // ---- stage 5: s = min(x*u >> 14, 1.0), apply sign ----
    t_q14        r5_s [4];
    t_diff       r5_dx, r5_dy;
    logic [4*SIZE_BITS-1:0] r5_sz;
    logic [15:0] w_sm [4];
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_sm[i] = 16'((30'(r4_x[i]) * 30'(r4_u[i])) >> 14);
            if (w_sm[i] > 16'(Q14_ONE)) w_sm[i] = 16'(Q14_ONE);
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 4; i++) begin
                r5_s[i] <= r4_neg[i] ? -$signed(w_sm[i]) : $signed(w_sm[i]);
            end
            r5_dx <= r4_dx; r5_dy <= r4_dy; r5_sz <= r4_sz;
        end
    end

    // Axes: 0 left up (-sl,cl), 1 left right (cl,sl), 2 right up, 3 right right
    t_q14 w_ux [4], w_uy [4];
    assign w_ux[0] = -r5_s[0]; assign w_uy[0] = r5_s[1];
    assign w_ux[1] =  r5_s[1]; assign w_uy[1] = r5_s[0];
    assign w_ux[2] = -r5_s[2]; assign w_uy[2] = r5_s[3];
    assign w_ux[3] =  r5_s[3]; assign w_uy[3] = r5_s[2];

    // ---- stage 6: axis products (centre projection, axis dot products) ----
    localparam int PW = 16 + COORD_BITS + 1;
    logic signed [PW-1:0] r6_pdx [4], r6_pdy [4];
    logic signed [31:0]   r6_cx [16], r6_cy [16];
    logic [4*SIZE_BITS-1:0] r6_sz;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 4; i++) begin
                r6_pdx[i] <= PW'(w_ux[i]) * PW'(r5_dx);
                r6_pdy[i] <= PW'(w_uy[i]) * PW'(r5_dy);
                for (int k = 0; k < 4; k++) begin
                    r6_cx[4*i+k] <= 32'(w_ux[i]) * 32'(w_ux[k]);
                    r6_cy[4*i+k] <= 32'(w_uy[i]) * 32'(w_uy[k]);
                end
            end
            r6_sz <= r5_sz;
        end
    end

    // ---- stage 7: abs and round, lhs = 2|A.d|, rhs terms c*size ----
    logic [PW+1:0]  r7_lhs [4];
    logic [32:0]    r7_term [16];
    logic signed [PW:0] w_pd [4];
    logic signed [32:0] w_c [16];
    logic [32:0]        w_ca [16];
    logic [16:0]        w_cr [16];
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_pd[i] = (PW+1)'(r6_pdx[i]) + (PW+1)'(r6_pdy[i]);
        end
        for (int j = 0; j < 16; j++) begin
            w_c[j]  = 33'(r6_cx[j]) + 33'(r6_cy[j]);
            w_ca[j] = w_c[j][32] ? 33'(-w_c[j]) : 33'(w_c[j]);
            w_cr[j] = 17'((w_ca[j] + 33'd8192) >> 14);
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 4; i++) begin
                r7_lhs[i] <= {(w_pd[i][PW] ? (PW+1)'(-w_pd[i]) : (PW+1)'(w_pd[i])), 1'b0};
            end
            for (int j = 0; j < 16; j++) begin
                r7_term[j] <= 33'(w_cr[j]) * 33'(r6_sz[(j%4)*SIZE_BITS +: SIZE_BITS]);
            end
        end
    end

    // ---- stage 8: sum terms per axis, compare, output register ----
    logic [34:0] w_rhs [4];
    logic        w_sep;
    always_comb begin
        w_sep = 1'b0;
        for (int i = 0; i < 4; i++) begin
            w_rhs[i] = 35'(r7_term[4*i]) + 35'(r7_term[4*i+1])
                     + 35'(r7_term[4*i+2]) + 35'(r7_term[4*i+3]);
            if ((PW+2 > 35 ? (PW+2)'(r7_lhs[i]) > (PW+2)'(w_rhs[i])
                           : 35'(r7_lhs[i]) > w_rhs[i])) w_sep = 1'b1;
        end
    end
    logic r8_ovl;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r8_ovl <= !w_sep;
        end
    end

    assign m_axis_tdata = {7'b0, r8_ovl};

endmodule

>>> rtl/obb_checker.sv
// ----------------------------------------------------------------------------
// obb_checker: port-level checks for obb_overlap_test_2d
// Watches the handshakes and the output item while it waits.
// ----------------------------------------------------------------------------
module obb_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [7:0]            m_axis_tdata
);

    // Output padding stays zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:1] == 7'b0)
        else $error("output padding not zero");

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Empty output never blocks input
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // Ready follows the output side
    a_rdy2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready |-> s_axis_tready)
        else $error("input blocked while output drains");

endmodule

bind obb_overlap_test_2d obb_checker u_obb_checker (.*);

>>> tb/tb_obb_overlap_test_2d.sv
// ----------------------------------------------------------------------------
// tb_obb_overlap_test_2d: self-checking bench for the 2D box overlap test
// Drives box pairs through the input stream with random bursts and gaps,
// predicts the overlap flag for every accepted item and compares it with
// each item leaving the output stream, which stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_obb_overlap_test_2d;
    import obb_pkg::*;

    typedef struct {
        logic signed [COORD_BITS-1:0] lcx, lcy;
        logic [SIZE_BITS-1:0]         lw, lh;
        logic [ANGLE_BITS-1:0]        la;
        logic signed [COORD_BITS-1:0] rcx, rcy;
        logic [SIZE_BITS-1:0]         rw, rh;
        logic [ANGLE_BITS-1:0]        ra;
    } t_box_pair;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // tdata, low bit up: left box x, y, width, height, angle, then right box
    logic [IN_BYTES_W-1:0] s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // tdata, low bit up: overlap[1], zero pad
    logic [7:0]            m_axis_tdata;

    bit expected_overlap[$];
    int mismatches = 0;
    int results_seen = 0;
    int burst_left = 0;
    bit stall_gen_on = 1'b1;

    obb_overlap_test_2d dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Q14 sine of a 16-bit phase, polynomial per quadrant
    function automatic longint phase_to_sine(input logic [15:0] phase);
        longint x, x2, t, u, s;
        x = phase[14] ? (Q14_ONE - longint'(phase[13:0])) : longint'(phase[13:0]);
        x2 = (x * x) >>> 14;
        t = 10512 - ((x2 * 1160) >>> 14);
        u = 25736 - ((x2 * t) >>> 14);
        s = (x * u) >>> 14;
        if (s > Q14_ONE) s = Q14_ONE;
        return phase[15] ? -s : s;
    endfunction

    function automatic longint mag(input longint v);
        return v < 0 ? -v : v;
    endfunction

    // Separating axis test over both boxes' up and right axes
    function automatic bit boxes_overlap(input t_box_pair p);
        logic [15:0] pl, pr;
        longint ax[4], ay[4], sz[4];
        longint dx, dy, sl, cl, sr, cr, lhs, rhs;
        bit hit;
        pl = 16'(p.la) << (16 - ANGLE_BITS);
        pr = 16'(p.ra) << (16 - ANGLE_BITS);
        sl = phase_to_sine(pl);
        cl = phase_to_sine(pl + 16'h4000);
        sr = phase_to_sine(pr);
        cr = phase_to_sine(pr + 16'h4000);
        dx = longint'(p.lcx) - longint'(p.rcx);
        dy = longint'(p.lcy) - longint'(p.rcy);
        ax[0] = -sl; ay[0] = cl; sz[0] = p.lh;
        ax[1] = cl;  ay[1] = sl; sz[1] = p.lw;
        ax[2] = -sr; ay[2] = cr; sz[2] = p.rh;
        ax[3] = cr;  ay[3] = sr; sz[3] = p.rw;
        hit = 1'b1;
        for (int i = 0; i < 4; i++) begin
            lhs = 2 * mag(ax[i] * dx + ay[i] * dy);
            rhs = 0;
            for (int k = 0; k < 4; k++)
                rhs += ((mag(ax[i] * ax[k] + ay[i] * ay[k]) + 8192) >>> 14) * sz[k];
            if (lhs > rhs) hit = 1'b0;
        end
        return hit;
    endfunction

    // Send one item: gaps between random bursts, valid held across a burst
    task automatic send_pair(input t_box_pair p);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) * ($urandom_range(0, 2) == 0);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_BYTES_W'({p.ra, p.rh, p.rw, p.rcy, p.rcx,
                                      p.la, p.lh, p.lw, p.lcy, p.lcx});
        do @(posedge i_clk); while (!s_axis_tready);
        expected_overlap.push_back(boxes_overlap(p));
        burst_left--;
    endtask

    function automatic t_box_pair random_pair(input bit close);
        t_box_pair p;
        p.lcx = COORD_BITS'($urandom); p.lcy = COORD_BITS'($urandom);
        p.rcx = COORD_BITS'($urandom); p.rcy = COORD_BITS'($urandom);
        p.lw = SIZE_BITS'($urandom); p.lh = SIZE_BITS'($urandom);
        p.rw = SIZE_BITS'($urandom); p.rh = SIZE_BITS'($urandom);
        p.la = ANGLE_BITS'($urandom); p.ra = ANGLE_BITS'($urandom);
        if (close) begin
            // keep centres near each other so both outcomes occur often
            p.rcx = p.lcx + COORD_BITS'($signed($urandom_range(0, 131071)) - 65536);
            p.rcy = p.lcy + COORD_BITS'($signed($urandom_range(0, 131071)) - 65536);
        end
        return p;
    endfunction

    task automatic test_extremes();
        t_box_pair p;
        p = '{default: '0};
        send_pair(p);                               // two points, same centre
        p.lcx = {1'b1, {(COORD_BITS-1){1'b0}}}; p.rcx = {1'b0, {(COORD_BITS-1){1'b1}}};
        p.lcy = {1'b0, {(COORD_BITS-1){1'b1}}}; p.rcy = {1'b1, {(COORD_BITS-1){1'b0}}};
        send_pair(p);                               // far corners, zero sizes
        p.lw = '1; p.lh = '1; p.rw = '1; p.rh = '1; p.la = '1; p.ra = '1;
        send_pair(p);                               // largest boxes, far apart
        p = '{default: '0};
        p.lw = SIZE_BITS'(160); p.lh = SIZE_BITS'(160);
        p.rw = SIZE_BITS'(160); p.rh = SIZE_BITS'(160);
        p.rcx = COORD_BITS'(160);
        send_pair(p);                               // edges touching
        p.rcx = COORD_BITS'(161);
        send_pair(p);                               // just apart
        p.lw = '0; p.lh = '0;
        p.rw = '1; p.rh = '1; p.rcx = COORD_BITS'(100);
        send_pair(p);                               // point inside a box
    endtask

    task automatic test_angles();
        t_box_pair p;
        p = '{default: '0};
        p.lw = SIZE_BITS'(320); p.lh = SIZE_BITS'(32);
        p.rw = SIZE_BITS'(320); p.rh = SIZE_BITS'(32);
        p.rcy = COORD_BITS'(100);
        for (int a = 0; a < 8; a++) begin
            p.la = ANGLE_BITS'(a * 512); p.ra = ANGLE_BITS'(4095 - a * 512);
            send_pair(p);
        end
        p.rcx = '0; p.rcy = '0; p.la = ANGLE_BITS'(1024); p.ra = ANGLE_BITS'(2048);
        send_pair(p);                               // coincident centres, rotated
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++)
            send_pair(random_pair($urandom_range(0, 9) != 0));
    endtask

    // Receiver: stall pattern of its own, with stall-free stretches
    always @(posedge i_clk) begin
        if (!stall_gen_on)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 99) < 70);
    end

    always @(posedge i_clk) begin
        if (($urandom_range(0, 199)) == 0) stall_gen_on <= ~stall_gen_on;
    end

    // Check every accepted result against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (expected_overlap.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d, nothing predicted", m_axis_tdata[0]);
            end else begin
                bit want;
                want = expected_overlap.pop_front();
                if (m_axis_tdata !== {7'b0, want}) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected overlap %0d, got tdata %h",
                                 results_seen, want, m_axis_tdata);
                end
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_angles();
        test_random(1000);
        s_axis_tvalid <= 1'b0;
        while (expected_overlap.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #400000;
        $display("FAIL");
        $finish;
    end

endmodule
